/* hw/rtl/slp_pkg.sv */
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types, constants and helpers for the status line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slp_pkg;

  localparam int LINE_CAPACITY    = 128;
  localparam int PROFILE_CAPACITY = 24;
  localparam int STATUS_CAPACITY  = 16;

  localparam int LineW     = $clog2(LINE_CAPACITY);
  localparam int TokCntW   = $clog2(STATUS_CAPACITY);
  localparam int TokenKeep = 12;
  localparam int TokIdxW   = $clog2(TokenKeep);
  localparam int NameDepth = 23;
  localparam int NameIdxW  = $clog2(NameDepth);
  localparam int NameCntW  = 5;
  // profile characters kept; never more than the output words hold
  localparam int NameKeep  = (PROFILE_CAPACITY - 1 < NameDepth) ?
                             PROFILE_CAPACITY - 1 : NameDepth;

  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_STATUS  = 3'd1,
    PH_PROFILE = 3'd2,
    PH_NUM1    = 3'd3,
    PH_NUM2    = 3'd4,
    PH_DONE    = 3'd5,
    PH_REJECT  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    LINK_UNKNOWN      = 3'd0,
    LINK_CONNECTED    = 3'd1,
    LINK_DISCONNECTED = 3'd2,
    LINK_RECONNECTING = 3'd3,
    LINK_ERROR        = 3'd4
  } link_state_e;

  typedef enum logic [1:0] {
    NUM_MORE  = 2'd0,
    NUM_COMMA = 2'd1,
    NUM_OTHER = 2'd2
  } num_end_e;

  typedef struct packed {
    logic sign;
    logic neg;
    logic digit;
    logic over;
  } num_flags_t;

  typedef struct packed {
    num_flags_t  flags;
    logic [31:0] mag;
    num_end_e    ending;
    logic [31:0] value;
  } num_res_t;

  function automatic logic [7:0] lead_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = "V";
      2'd1:    c = "P";
      2'd2:    c = "N";
      default: c = ",";
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/slp_num_unit.sv */
// ----------------------------------------------------------------------------
// slp_num_unit
// One step of the decimal field decoder: skips leading blanks, takes a sign,
// accumulates digits with saturation and reports how the field ended.
// ----------------------------------------------------------------------------
`default_nettype none

module slp_num_unit (
  input  wire logic [7:0]          byte_i,
  input  wire logic [31:0]         mag_i,
  input  wire slp_pkg::num_flags_t flags_i,
  output slp_pkg::num_res_t        res_o
);

  logic        lead_ok;
  logic        is_blank;
  logic        is_digit;
  logic [35:0] prod;

  always_comb begin
    lead_ok  = !(flags_i.sign || flags_i.digit);
    is_blank = (byte_i == slp_pkg::ChSpace) || (byte_i == slp_pkg::ChTab) ||
               (byte_i == slp_pkg::ChVt) || (byte_i == slp_pkg::ChFf);
    is_digit = (byte_i >= slp_pkg::ChZero) && (byte_i <= slp_pkg::ChNine);
    prod     = ({4'b0, mag_i} << 3) + ({4'b0, mag_i} << 1) + 36'(byte_i[3:0]);

    res_o.flags  = flags_i;
    res_o.mag    = mag_i;
    res_o.ending = slp_pkg::NUM_MORE;

    if (lead_ok && is_blank) begin
      res_o.flags = flags_i;
    end else if (lead_ok && (byte_i == slp_pkg::ChPlus || byte_i == slp_pkg::ChMinus)) begin
      res_o.flags.sign = 1'b1;
      res_o.flags.neg  = (byte_i == slp_pkg::ChMinus);
    end else if (is_digit) begin
      res_o.flags.digit = 1'b1;
      if (!flags_i.over) begin
        if (prod[35:32] != 4'd0) begin
          res_o.flags.over = 1'b1;
        end else begin
          res_o.mag = prod[31:0];
        end
      end
    end else if (byte_i == slp_pkg::ChComma && flags_i.digit) begin
      res_o.ending = slp_pkg::NUM_COMMA;
    end else begin
      res_o.ending = slp_pkg::NUM_OTHER;
    end

    // final value of the field as it stands before this byte
    if (!flags_i.digit) begin
      res_o.value = 32'd0;
    end else if (flags_i.over) begin
      res_o.value = 32'hffff_ffff;
    end else if (flags_i.neg) begin
      res_o.value = 32'd0 - mag_i;
    end else begin
      res_o.value = mag_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/status_line_parser.sv */
// ----------------------------------------------------------------------------
// status_line_parser
// Assembles "VPN,status,profile,uptime,reconnects" lines from a byte stream
// and emits one decoded record per well formed line.
// ----------------------------------------------------------------------------
//   channel | dir | handshake              | payload
//   rx      | in  | rx_valid_i / rx_stall_o | rx_byte_i
//   res     | out | res_valid_o / res_stall_i | link_state_o, profile_*_o,
//           |     |                        | uptime_seconds_o, reconnect_total_o
//
// One byte per cycle sustained while no record waits under res_stall_i. A
// byte is captured in the input register and decoded from there, and a line
// end loads the result register, from which the record is valid.
// Reset clears all line state; no clearing pass is needed.
// While a record waits under res_stall_i the input register holds and
// rx_stall_o rises once it is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module status_line_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rx_valid_i,
  output logic             rx_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  input  wire logic        res_stall_i,
  output logic [2:0]       link_state_o,
  output logic [63:0]      profile_low_word_o,
  output logic [63:0]      profile_mid_word_o,
  output logic [63:0]      profile_high_word_o,
  output logic [4:0]       profile_count_o,
  output logic [31:0]      uptime_seconds_o,
  output logic [31:0]      reconnect_total_o
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       proc;
  logic       rx_take;

  // line state
  logic [slp_pkg::LineW-1:0]    line_cnt_q, line_cnt_d;
  slp_pkg::phase_e              phase_q, phase_d;
  logic [2:0]                   pfx_q, pfx_d;
  logic [slp_pkg::TokCntW-1:0]  tok_cnt_q, tok_cnt_d;
  logic [slp_pkg::NameCntW-1:0] name_cnt_q, name_cnt_d;
  logic [31:0]                  first_q, first_d;
  logic [31:0]                  second_q, second_d;
  slp_pkg::num_flags_t          flags_q, flags_d;
  logic                         zero_q, zero_d;
  logic [7:0]                   tok_mem_q [slp_pkg::TokenKeep];
  logic [7:0]                   name_mem_q [slp_pkg::NameDepth];
  logic                         tok_we, name_we;

  // number decoder
  logic [31:0]        num_mag;
  slp_pkg::num_res_t  num_res;

  // result
  logic               emit;
  logic               out_vld_q, out_vld_d;
  logic [2:0]         link_q;
  logic [63:0]        word0_q, word1_q, word2_q;
  logic [4:0]         pcnt_q;
  logic [31:0]        up_q, rec_q;
  logic [31:0]        fin_first, fin_second;
  slp_pkg::link_state_e link_cls;
  logic [191:0]       words;
  logic               line_end;

  function automatic logic tok_hit(input logic [7:0] st [slp_pkg::TokenKeep],
                                   input logic [slp_pkg::TokCntW-1:0] cnt,
                                   input logic [8*slp_pkg::TokenKeep-1:0] word,
                                   input int len);
    logic hit;
    hit = (int'(cnt) >= len);
    for (int i = 0; i < slp_pkg::TokenKeep; i++) begin
      if (i < len) begin
        if (st[i] != word[8*(len-1-i) +: 8]) hit = 1'b0;
      end
    end
    return hit;
  endfunction

  assign proc       = in_vld_q && (!out_vld_q || !res_stall_i);
  assign rx_stall_o = in_vld_q && !proc;
  assign rx_take    = rx_valid_i && !rx_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (rx_take) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  assign num_mag = (phase_q == slp_pkg::PH_NUM2) ? second_q : first_q;

  slp_num_unit u_num (
    .byte_i  (byte_q),
    .mag_i   (num_mag),
    .flags_i (flags_q),
    .res_o   (num_res)
  );

  always_comb begin
    if (tok_hit(tok_mem_q, tok_cnt_q, 96'("OK"), 2) ||
        tok_hit(tok_mem_q, tok_cnt_q, 96'("CONNECTED"), 9)) begin
      link_cls = slp_pkg::LINK_CONNECTED;
    end else if (tok_hit(tok_mem_q, tok_cnt_q, 96'("DOWN"), 4) ||
                 tok_hit(tok_mem_q, tok_cnt_q, 96'("DISCONNECTED"), 12)) begin
      link_cls = slp_pkg::LINK_DISCONNECTED;
    end else if (tok_hit(tok_mem_q, tok_cnt_q, 96'("RECON"), 5)) begin
      link_cls = slp_pkg::LINK_RECONNECTING;
    end else if (tok_hit(tok_mem_q, tok_cnt_q, 96'("ERR"), 3)) begin
      link_cls = slp_pkg::LINK_ERROR;
    end else begin
      link_cls = slp_pkg::LINK_UNKNOWN;
    end
  end

  always_comb begin
    words = '0;
    for (int i = 0; i < slp_pkg::NameDepth; i++) begin
      if (i < int'(name_cnt_q)) words[8*i +: 8] = name_mem_q[i];
    end
  end

  assign fin_first  = (phase_q == slp_pkg::PH_NUM1) ? num_res.value : first_q;
  assign fin_second = (phase_q == slp_pkg::PH_NUM2) ? num_res.value : second_q;

  always_comb begin
    line_cnt_d = line_cnt_q;
    phase_d    = phase_q;
    pfx_d      = pfx_q;
    tok_cnt_d  = tok_cnt_q;
    name_cnt_d = name_cnt_q;
    first_d    = first_q;
    second_d   = second_q;
    flags_d    = flags_q;
    zero_d     = zero_q;
    tok_we     = 1'b0;
    name_we    = 1'b0;
    emit       = 1'b0;
    line_end   = 1'b0;

    if (proc) begin
      if (byte_q == slp_pkg::ChLf || byte_q == slp_pkg::ChCr) begin
        if (line_cnt_q != '0) begin
          line_end = 1'b1;
          emit = (phase_q == slp_pkg::PH_NUM1) || (phase_q == slp_pkg::PH_NUM2) ||
                 (phase_q == slp_pkg::PH_DONE) ||
                 (phase_q == slp_pkg::PH_PROFILE && name_cnt_q != '0);
        end
      end else if (line_cnt_q < slp_pkg::LineW'(slp_pkg::LINE_CAPACITY - 1)) begin
        line_cnt_d = line_cnt_q + 1'b1;
        if (zero_q) begin
          zero_d = 1'b1;
        end else if (byte_q == slp_pkg::ChNul) begin
          zero_d = 1'b1;
        end else begin
          case (phase_q)
            slp_pkg::PH_PREFIX: begin
              if (pfx_q < 3'd4 && byte_q == slp_pkg::lead_char(pfx_q[1:0])) begin
                pfx_d = pfx_q + 3'd1;
                if (pfx_q == 3'd3) phase_d = slp_pkg::PH_STATUS;
              end else begin
                phase_d = slp_pkg::PH_REJECT;
              end
            end
            slp_pkg::PH_STATUS: begin
              if (byte_q == slp_pkg::ChComma) begin
                phase_d = (tok_cnt_q == '0) ? slp_pkg::PH_REJECT : slp_pkg::PH_PROFILE;
              end else if (tok_cnt_q >=
                           slp_pkg::TokCntW'(slp_pkg::STATUS_CAPACITY - 1)) begin
                phase_d = slp_pkg::PH_REJECT;
              end else begin
                tok_we    = (tok_cnt_q < slp_pkg::TokCntW'(slp_pkg::TokenKeep));
                tok_cnt_d = tok_cnt_q + 1'b1;
              end
            end
            slp_pkg::PH_PROFILE: begin
              if (byte_q == slp_pkg::ChComma) begin
                phase_d = (name_cnt_q == '0) ? slp_pkg::PH_REJECT : slp_pkg::PH_NUM1;
              end else if (name_cnt_q >= slp_pkg::NameCntW'(slp_pkg::NameKeep)) begin
                phase_d = slp_pkg::PH_DONE;
              end else begin
                name_we    = 1'b1;
                name_cnt_d = name_cnt_q + 1'b1;
              end
            end
            slp_pkg::PH_NUM1, slp_pkg::PH_NUM2: begin
              if (num_res.ending == slp_pkg::NUM_MORE) begin
                flags_d = num_res.flags;
                if (phase_q == slp_pkg::PH_NUM1) first_d = num_res.mag;
                else second_d = num_res.mag;
              end else begin
                flags_d = '0;
                if (phase_q == slp_pkg::PH_NUM1) begin
                  first_d = num_res.value;
                  phase_d = (num_res.ending == slp_pkg::NUM_COMMA) ?
                            slp_pkg::PH_NUM2 : slp_pkg::PH_DONE;
                end else begin
                  second_d = num_res.value;
                  phase_d  = slp_pkg::PH_DONE;
                end
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end else begin
        line_end = 1'b1;
      end
    end

    if (line_end) begin
      line_cnt_d = '0;
      phase_d    = slp_pkg::PH_PREFIX;
      pfx_d      = 3'd0;
      tok_cnt_d  = '0;
      name_cnt_d = '0;
      first_d    = 32'd0;
      second_d   = 32'd0;
      flags_d    = '0;
      zero_d     = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (!res_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      line_cnt_q <= '0;
      phase_q    <= slp_pkg::PH_PREFIX;
      pfx_q      <= 3'd0;
      tok_cnt_q  <= '0;
      name_cnt_q <= '0;
      first_q    <= 32'd0;
      second_q   <= 32'd0;
      flags_q    <= '0;
      zero_q     <= 1'b0;
    end else begin
      in_vld_q   <= in_vld_d;
      out_vld_q  <= out_vld_d;
      line_cnt_q <= line_cnt_d;
      phase_q    <= phase_d;
      pfx_q      <= pfx_d;
      tok_cnt_q  <= tok_cnt_d;
      name_cnt_q <= name_cnt_d;
      first_q    <= first_d;
      second_q   <= second_d;
      flags_q    <= flags_d;
      zero_q     <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) byte_q <= rx_byte_i;
    if (tok_we) tok_mem_q[tok_cnt_q[slp_pkg::TokIdxW-1:0]] <= byte_q;
    if (name_we) name_mem_q[name_cnt_q[slp_pkg::NameIdxW-1:0]] <= byte_q;
    if (emit) begin
      link_q  <= link_cls;
      word0_q <= words[63:0];
      word1_q <= words[127:64];
      word2_q <= words[191:128];
      pcnt_q  <= name_cnt_q;
      up_q    <= fin_first;
      rec_q   <= fin_second;
    end
  end

  assign res_valid_o         = out_vld_q;
  assign link_state_o        = link_q;
  assign profile_low_word_o  = word0_q;
  assign profile_mid_word_o  = word1_q;
  assign profile_high_word_o = word2_q;
  assign profile_count_o     = pcnt_q;
  assign uptime_seconds_o    = up_q;
  assign reconnect_total_o   = rec_q;

endmodule

`default_nettype wire

/* hw/rtl/slp_checker.sv */
// ----------------------------------------------------------------------------
// slp_checker
// Port level checks on the status line parser, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid_o,
  input wire logic        res_stall_i,
  input wire logic [2:0]  link_state_o,
  input wire logic [63:0] profile_mid_word_o,
  input wire logic [63:0] profile_high_word_o,
  input wire logic [4:0]  profile_count_o,
  input wire logic [31:0] uptime_seconds_o,
  input wire logic [31:0] reconnect_total_o
);

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o)
    else $error("result transaction dropped while stalled");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> $stable(uptime_seconds_o) &&
      $stable(reconnect_total_o) && $stable(profile_count_o))
    else $error("stalled result transaction changed");

  a_ranges : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> profile_count_o != 5'd0 && profile_count_o <= 5'd23 &&
      link_state_o <= 3'd4)
    else $error("result field out of range");

  a_short_profile : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && profile_count_o <= 5'd8 |->
      profile_mid_word_o == 64'd0 && profile_high_word_o == 64'd0)
    else $error("profile bytes beyond length not zero");

  a_last_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> profile_high_word_o[63:56] == 8'd0)
    else $error("profile byte 23 not zero");

endmodule

bind status_line_parser slp_checker u_slp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .res_valid_o         (res_valid_o),
  .res_stall_i         (res_stall_i),
  .link_state_o        (link_state_o),
  .profile_mid_word_o  (profile_mid_word_o),
  .profile_high_word_o (profile_high_word_o),
  .profile_count_o     (profile_count_o),
  .uptime_seconds_o    (uptime_seconds_o),
  .reconnect_total_o   (reconnect_total_o)
);

`default_nettype wire
